[rtl/sbat_pkg.sv]
// shared types, codes and key compare functions for the sprite sort and batch block
package sbat_pkg;

   localparam int TEX_W   = 16;
   localparam int DEPTH_W = 16;
   localparam int IDX_OUT_W = 5;
   localparam int BATCH_W = 5;
   localparam int VOFF_W  = 8;

   localparam logic [1:0] MODE_KEEP       = 2'd0;
   localparam logic [1:0] MODE_DEPTH_UP   = 2'd1;
   localparam logic [1:0] MODE_DEPTH_DOWN = 2'd2;
   localparam logic [1:0] MODE_TEXTURE    = 2'd3;

   typedef struct packed {
      logic [TEX_W-1:0]          texture_id;
      logic signed [DEPTH_W-1:0] depth_key;
      logic                      last_glyph;
   } req_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] glyph_index;
      logic [TEX_W-1:0]     out_texture;
      logic [BATCH_W-1:0]   batch_index;
      logic [VOFF_W-1:0]    batch_vertex_offset;
      logic                 ends_batch;
      logic                 last_result;
      logic                 dropped_any;
   } rsp_type;

   // sprite payload held in one cell
   typedef struct packed {
      logic [TEX_W-1:0]          texture;
      logic signed [DEPTH_W-1:0] depth;
   } data_type;

   // per-cycle command broadcast to the cell row
   typedef struct packed {
      logic       load;
      logic       sort;
      logic       phase;
      logic       drain;
      logic [1:0] mode;
   } ctl_type;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_SORT,
      ST_DRAIN
   } state_type;

   // key of a sorts strictly before key of b in the given mode
   function automatic logic key_lt(input logic [1:0] mode, input data_type a,
                                   input data_type b);
      logic r;
      case (mode)
         MODE_DEPTH_UP:   r = a.depth < b.depth;
         MODE_DEPTH_DOWN: r = a.depth > b.depth;
         MODE_TEXTURE:    r = a.texture < b.texture;
         default:         r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic key_eq(input logic [1:0] mode, input data_type a,
                                   input data_type b);
      logic r;
      case (mode)
         MODE_DEPTH_UP, MODE_DEPTH_DOWN: r = a.depth == b.depth;
         MODE_TEXTURE:                   r = a.texture == b.texture;
         default:                        r = 1'b1;
      endcase
      return r;
   endfunction

endpackage

[rtl/stable_sort_and_texture_batcher.sv]
// sprite sort and texture batch top level: sequencer, cell row and result register
// sequence: after the last request of a frame the row runs odd-even exchange rounds, then
// drains the held sprites, each shown through the result register; results come back to back
// throughput: one request per cycle while filling; busy is high while the row sorts and drains
// after a frame closes; results cannot be stalled
// reset: synchronous, clears held count and overflow flag, mode texture ascending, cells kept
module stable_sort_and_texture_batcher #(
   parameter int MAX_GLYPHS       = 32,
   parameter int VERTS_PER_SPRITE = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sbat_pkg::req_type req,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data,
   output logic              rsp_valid,
   output sbat_pkg::rsp_type rsp
);
   import sbat_pkg::*;

   localparam int IDX_W = $clog2(MAX_GLYPHS);
   localparam int CNT_W = $clog2(MAX_GLYPHS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_GLYPHS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [VOFF_W-1:0] VERT_STEP = VOFF_W'(VERTS_PER_SPRITE);

   state_type        state_ff, state_in;
   logic [1:0]       mode_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rounds_ff;
   logic             phase_ff;
   logic             overflow_ff;
   logic             first_ff;
   logic [TEX_W-1:0] prev_tex_ff;
   logic [BATCH_W-1:0] batch_ff, batch_in;
   logic [VOFF_W-1:0]  off_ff, off_in;
   logic [VOFF_W-1:0]  vert_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             accept, full, new_batch;
   ctl_type          ctl;

   data_type         cell_data [MAX_GLYPHS];
   logic [IDX_W-1:0] cell_arr  [MAX_GLYPHS];
   logic             cell_vld  [MAX_GLYPHS];

   assign full   = (count_ff == CNT_MAX);
   assign accept = start && !busy;

   always_comb begin
      count_in = count_ff;
      if (accept && !full)
         count_in = count_ff + CNT_ONE;
      else if (state_ff == ST_DRAIN)
         count_in = count_ff - CNT_ONE;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (start && req.last_glyph) state_in = ST_SORT;
         end
         ST_SORT: begin
            if (rounds_ff == CNT_ONE) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (count_ff == CNT_ONE) state_in = ST_FILL;
         end
         default: state_in = ST_FILL;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      busy         = 1'b1;
      ctl.load     = 1'b0;
      ctl.sort     = 1'b0;
      ctl.drain    = 1'b0;
      ctl.phase    = phase_ff;
      ctl.mode     = mode_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_FILL: begin
            busy     = 1'b0;
            ctl.load = start && !full;
         end
         ST_SORT: begin
            ctl.sort = 1'b1;
         end
         ST_DRAIN: begin
            ctl.drain    = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

   // cell row
   for (genvar i = 0; i < MAX_GLYPHS; i++) begin : g_cell
      localparam logic [CNT_W-1:0] POS = CNT_W'(i);
      logic             lv, rv;
      data_type         ld, rd;
      logic [IDX_W-1:0] la, ra;

      assign cell_vld[i] = (POS < count_ff);

      if (i == 0) begin : g_head
         assign lv = 1'b0;
         assign ld.texture = req.texture_id;
         assign ld.depth   = req.depth_key;
         assign la = count_ff[IDX_W-1:0];
      end else begin : g_mid_l
         assign lv = cell_vld[i-1];
         assign ld = cell_data[i-1];
         assign la = cell_arr[i-1];
      end

      if (i == MAX_GLYPHS - 1) begin : g_tail
         assign rv = 1'b0;
         assign rd = '0;
         assign ra = '0;
      end else begin : g_mid_r
         assign rv = cell_vld[i+1];
         assign rd = cell_data[i+1];
         assign ra = cell_arr[i+1];
      end

      sbat_cell #(
         .IDX_W  (IDX_W),
         .POS_ODD(i % 2 == 1)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .self_valid (cell_vld[i]),
         .left_valid (lv),
         .left_data  (ld),
         .left_arr   (la),
         .right_valid(rv),
         .right_data (rd),
         .right_arr  (ra),
         .data       (cell_data[i]),
         .arr        (cell_arr[i])
      );
   end

   // batch bookkeeping for the sprite leaving the head cell
   always_comb begin
      new_batch = !first_ff && (cell_data[0].texture != prev_tex_ff);
      batch_in  = first_ff ? '0 : batch_ff + BATCH_W'(new_batch);
      off_in    = first_ff ? '0 : (new_batch ? vert_ff : off_ff);
      rsp_in.glyph_index         = IDX_OUT_W'(cell_arr[0]);
      rsp_in.out_texture         = cell_data[0].texture;
      rsp_in.batch_index         = batch_in;
      rsp_in.batch_vertex_offset = off_in;
      rsp_in.last_result         = (count_ff == CNT_ONE);
      rsp_in.ends_batch          = (count_ff == CNT_ONE) ||
                                   (cell_data[1].texture != cell_data[0].texture);
      rsp_in.dropped_any         = overflow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         mode_ff      <= MODE_TEXTURE;
         count_ff     <= '0;
         rounds_ff    <= '0;
         phase_ff     <= 1'b0;
         overflow_ff  <= 1'b0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) mode_ff <= csr_wr_data;
         if (accept && full) overflow_ff <= 1'b1;
         else if (state_ff == ST_DRAIN && count_ff == CNT_ONE) overflow_ff <= 1'b0;
         if (state_ff == ST_SORT) begin
            rounds_ff <= rounds_ff - CNT_ONE;
            phase_ff  <= !phase_ff;
         end else begin
            rounds_ff <= count_in;
            phase_ff  <= 1'b0;
         end
         if (state_ff == ST_DRAIN) first_ff <= 1'b0;
         else                      first_ff <= 1'b1;
      end
   end

   // result and batch payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (state_ff == ST_DRAIN) begin
         prev_tex_ff <= cell_data[0].texture;
         batch_ff    <= batch_in;
         off_ff      <= off_in;
         vert_ff     <= vert_ff + VERT_STEP;
      end else begin
         vert_ff <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_DRAIN))
      else $error("result shown without a drain cycle");

   a_last_frees_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last_result) |-> (state_ff == ST_FILL))
      else $error("final result shown but block still busy");

   a_sort_has_items: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT) |-> (count_ff != '0 && rounds_ff != '0))
      else $error("sort running on an empty row");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("held count beyond capacity");

endmodule

[rtl/sbat_cell.sv]
// one cell of the sprite row: shift in, odd-even compare-exchange, shift out
module sbat_cell #(
   parameter int IDX_W   = 5,
   parameter bit POS_ODD = 1'b0
) (
   input  logic                   clock,
   input  sbat_pkg::ctl_type      ctl,
   input  logic                   self_valid,
   input  logic                   left_valid,
   input  sbat_pkg::data_type     left_data,
   input  logic [IDX_W-1:0]       left_arr,
   input  logic                   right_valid,
   input  sbat_pkg::data_type     right_data,
   input  logic [IDX_W-1:0]       right_arr,
   output sbat_pkg::data_type     data,
   output logic [IDX_W-1:0]       arr
);
   import sbat_pkg::*;

   data_type         data_ff, data_in;
   logic [IDX_W-1:0] arr_ff, arr_in;
   logic             pair_right, take_right, take_left;

   // total order: key first, arrival breaks ties so equal keys keep arrival order
   function automatic logic goes_first(input logic [1:0] mode,
                                       input data_type a, input logic [IDX_W-1:0] aa,
                                       input data_type b, input logic [IDX_W-1:0] ba);
      return key_lt(mode, a, b) || (key_eq(mode, a, b) && (aa < ba));
   endfunction

   always_comb begin
      pair_right = (ctl.phase == POS_ODD);
      take_right = pair_right && self_valid && right_valid &&
                   goes_first(ctl.mode, right_data, right_arr, data_ff, arr_ff);
      take_left  = !pair_right && self_valid && left_valid &&
                   goes_first(ctl.mode, data_ff, arr_ff, left_data, left_arr);
      data_in = data_ff;
      arr_in  = arr_ff;
      if (ctl.load || (ctl.sort && take_left)) begin
         data_in = left_data;
         arr_in  = left_arr;
      end else if (ctl.drain || (ctl.sort && take_right)) begin
         data_in = right_data;
         arr_in  = right_arr;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      arr_ff  <= arr_in;
   end

   assign data = data_ff;
   assign arr  = arr_ff;

endmodule
